[rtl/core/eqd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eqd_pkg
// Shared types and codes of the event queue dispatcher: request and result
// payloads, request kinds, result status codes and ring slot layout.
// ----------------------------------------------------------------------------
package eqd_pkg;

    localparam int PAYLOAD_BYTES = 16;
    localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
    localparam int BYTE_CNT_W    = $clog2(PAYLOAD_BYTES + 1);

    // request kinds
    localparam logic [1:0] KIND_PUBLISH   = 2'd0;
    localparam logic [1:0] KIND_SUBSCRIBE = 2'd1;
    localparam logic [1:0] KIND_PROCESS   = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_PUBLISHED   = 3'd0;
    localparam logic [2:0] STAT_PUB_DROP    = 3'd1;
    localparam logic [2:0] STAT_BAD_TYPE    = 3'd2;
    localparam logic [2:0] STAT_SUBSCRIBED  = 3'd3;
    localparam logic [2:0] STAT_LIST_FULL   = 3'd4;
    localparam logic [2:0] STAT_DELIVERY    = 3'd5;
    localparam logic [2:0] STAT_DRAIN_DONE  = 3'd6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  event_type;
        logic [1:0]  priority_req;
        logic [31:0] timestamp;
        logic        payload_present;
        logic [7:0]  payload_len;
        logic [63:0] payload_low;
        logic [63:0] payload_high;
        logic [7:0]  subscriber_id;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  target_id;
        logic [3:0]  out_type;
        logic [1:0]  out_priority;
        logic [31:0] out_timestamp;
        logic [63:0] out_payload_low;
        logic [63:0] out_payload_high;
        logic [3:0]  fill_level;
        logic [3:0]  drained_count;
        logic        last;
    } out_item_t;

    // ring slot header, payload is held apart with byte enables
    typedef struct packed {
        logic [3:0]  ev_type;
        logic [1:0]  ev_priority;
        logic [31:0] ev_time;
    } slot_meta_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic drain_start;
        logic do_simple;
        logic ring_rd;
        logic hdr_load;
        logic sub_rd;
        logic deliver;
        logic ev_next;
        logic done;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic rem_zero;
        logic sub_more;
    } dp_sts_t;

endpackage
`default_nettype wire

[rtl/core/eqd_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eqd_ctrl
// Sequencer: accepts one request at a time and steps the datapath through
// publish / subscribe commit or the drain loop over events and subscribers.
// ----------------------------------------------------------------------------
module eqd_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       in_kind,
    input  wire eqd_pkg::dp_sts_t sts,
    output eqd_pkg::dp_cmd_t      cmd
);
    import eqd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_NEXT_EV,
        ST_HDR,
        ST_CHK_SUB,
        ST_SUB_OUT,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    unique case (in_kind)
                        KIND_PUBLISH, KIND_SUBSCRIBE: state_next = ST_EXEC;
                        KIND_PROCESS: begin
                            cmd.drain_start = 1'b1;
                            state_next      = ST_NEXT_EV;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EXEC: begin
                if (sts.out_free) begin
                    cmd.do_simple = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_NEXT_EV: begin
                if (sts.rem_zero) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.ring_rd = 1'b1;
                    state_next  = ST_HDR;
                end
            end
            ST_HDR: begin
                cmd.hdr_load = 1'b1;
                state_next   = ST_CHK_SUB;
            end
            ST_CHK_SUB: begin
                if (sts.sub_more) begin
                    cmd.sub_rd = 1'b1;
                    state_next = ST_SUB_OUT;
                end else begin
                    cmd.ev_next = 1'b1;
                    state_next  = ST_NEXT_EV;
                end
            end
            ST_SUB_OUT: begin
                if (sts.out_free) begin
                    cmd.deliver = 1'b1;
                    state_next  = ST_CHK_SUB;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.done   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

[rtl/core/eqd_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eqd_datapath
// Event ring memory, subscriber table memory, per-type tallies, pointers and
// the result register, driven by commands from the sequencer.
// ----------------------------------------------------------------------------
module eqd_datapath #(
    parameter int QUEUE_DEPTH   = 8,
    parameter int SUBS_PER_TYPE = 4,
    parameter int EVENT_TYPES   = 11
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire eqd_pkg::in_item_t s_data,
    input  wire eqd_pkg::dp_cmd_t  cmd,
    output eqd_pkg::dp_sts_t       sts,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output eqd_pkg::out_item_t     m_data
);
    import eqd_pkg::*;

    localparam int QP_W      = $clog2(QUEUE_DEPTH);
    localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int TC_W      = $clog2(SUBS_PER_TYPE + 1);
    localparam int TI_W      = (EVENT_TYPES > 1) ? $clog2(EVENT_TYPES) : 1;
    localparam int SUB_DEPTH = EVENT_TYPES * SUBS_PER_TYPE;
    localparam int SA_W      = (SUB_DEPTH > 1) ? $clog2(SUB_DEPTH) : 1;

    function automatic logic [QP_W-1:0] bump(input logic [QP_W-1:0] p);
        return (p == QP_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // memories
    slot_meta_t             meta_mem [QUEUE_DEPTH];
    logic [PAYLOAD_W-1:0]   pay_mem  [QUEUE_DEPTH];
    logic [7:0]             sub_mem  [SUB_DEPTH];

    slot_meta_t             meta_rd_reg;
    logic [PAYLOAD_W-1:0]   pay_rd_reg;
    logic [7:0]             sub_rd_reg;

    // control registers
    in_item_t               req_reg;
    logic [QP_W-1:0]        wp_reg, wp_next;
    logic [QP_W-1:0]        rp_reg, rp_next;
    logic [OCC_W-1:0]       occ_reg, occ_next;
    logic [OCC_W-1:0]       rem_reg, rem_next;
    logic [OCC_W-1:0]       drained_reg, drained_next;
    logic [QUEUE_DEPTH-1:0] slot_valid_reg, slot_valid_next;
    logic [TC_W-1:0]        tally_reg [EVENT_TYPES];
    logic [TC_W-1:0]        ev_cnt_reg, ev_cnt_next;
    logic [TC_W-1:0]        sub_idx_reg, sub_idx_next;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_data_reg, m_data_next;

    // decode of the held request
    logic                   is_pub, is_sub, req_type_ok, ring_full, list_full;
    logic                   pay_clear, ring_we, sub_we, out_free;
    logic [TI_W-1:0]        tally_idx;
    logic [TC_W-1:0]        tally_rd;
    logic                   hdr_type_ok;
    logic [OCC_W-1:0]       occ_after;
    logic [BYTE_CNT_W-1:0]  n_bytes;
    logic [PAYLOAD_BYTES-1:0] byte_mask, byte_en;
    logic [PAYLOAD_W-1:0]   pay_in, pay_wdata;
    logic [SA_W-1:0]        sub_waddr, sub_raddr;

    assign out_free    = !m_valid_reg || m_ready;
    assign is_pub      = (req_reg.kind == KIND_PUBLISH);
    assign is_sub      = (req_reg.kind == KIND_SUBSCRIBE);
    assign req_type_ok = (32'(req_reg.event_type) < EVENT_TYPES);
    assign hdr_type_ok = (32'(meta_rd_reg.ev_type) < EVENT_TYPES);
    assign ring_full   = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign occ_after   = ring_full ? occ_reg : occ_reg + 1'b1;

    // single tally read port, event type of the request or of the ring head
    assign tally_idx = cmd.hdr_load ? meta_rd_reg.ev_type[TI_W-1:0]
                                    : req_reg.event_type[TI_W-1:0];
    assign tally_rd  = tally_reg[tally_idx];
    assign list_full = (tally_rd == TC_W'(SUBS_PER_TYPE));

    assign ring_we = cmd.do_simple && is_pub && req_type_ok;
    assign sub_we  = cmd.do_simple && is_sub && req_type_ok && !list_full;

    assign sub_waddr = SA_W'(32'(req_reg.event_type) * SUBS_PER_TYPE + 32'(tally_rd));
    assign sub_raddr = SA_W'(32'(meta_rd_reg.ev_type) * SUBS_PER_TYPE + 32'(sub_idx_reg));

    // payload byte enables: first min(size,16) bytes, whole slot when cleared
    // or when the slot holds nothing written since reset
    assign pay_clear = !req_reg.payload_present || (req_reg.payload_len == 8'd0);
    assign n_bytes   = (req_reg.payload_len > 8'(PAYLOAD_BYTES))
                       ? BYTE_CNT_W'(PAYLOAD_BYTES)
                       : req_reg.payload_len[BYTE_CNT_W-1:0];
    assign pay_in    = {req_reg.payload_high, req_reg.payload_low};

    always_comb begin
        for (int b = 0; b < PAYLOAD_BYTES; b++) begin
            byte_mask[b] = !pay_clear && (BYTE_CNT_W'(b) < n_bytes);
            pay_wdata[b*8 +: 8] = byte_mask[b] ? pay_in[b*8 +: 8] : 8'h00;
        end
        byte_en = (pay_clear || !slot_valid_reg[wp_reg]) ? '1 : byte_mask;
    end

    // ring memory
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            meta_mem[wp_reg] <= '{ev_type:     req_reg.event_type,
                                  ev_priority: req_reg.priority_req,
                                  ev_time:     req_reg.timestamp};
            for (int b = 0; b < PAYLOAD_BYTES; b++) begin
                if (byte_en[b]) begin
                    pay_mem[wp_reg][b*8 +: 8] <= pay_wdata[b*8 +: 8];
                end
            end
        end
        if (cmd.ring_rd) begin
            meta_rd_reg <= meta_mem[rp_reg];
            pay_rd_reg  <= pay_mem[rp_reg];
        end
    end

    // subscriber table memory
    always_ff @(posedge aclk) begin
        if (sub_we) begin
            sub_mem[sub_waddr] <= req_reg.subscriber_id;
        end
        if (cmd.sub_rd) begin
            sub_rd_reg <= sub_mem[sub_raddr];
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data;
        end
    end

    // pointers, counts and drain bookkeeping
    always_comb begin
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        occ_next        = occ_reg;
        rem_next        = rem_reg;
        drained_next    = drained_reg;
        slot_valid_next = slot_valid_reg;
        ev_cnt_next     = ev_cnt_reg;
        sub_idx_next    = sub_idx_reg;
        if (cmd.drain_start) begin
            rem_next     = occ_reg;
            drained_next = occ_reg;
            occ_next     = '0;
        end
        if (ring_we) begin
            wp_next                 = bump(wp_reg);
            occ_next                = occ_after;
            slot_valid_next[wp_reg] = 1'b1;
            if (ring_full) begin
                rp_next = bump(rp_reg);
            end
        end
        if (cmd.hdr_load) begin
            ev_cnt_next  = hdr_type_ok ? tally_rd : '0;
            sub_idx_next = '0;
        end
        if (cmd.deliver) begin
            sub_idx_next = sub_idx_reg + 1'b1;
        end
        if (cmd.ev_next) begin
            rp_next  = bump(rp_reg);
            rem_next = rem_reg - 1'b1;
        end
    end

    // result register
    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.do_simple) begin
            m_data_next            = '0;
            m_data_next.last       = 1'b1;
            m_data_next.fill_level = 4'(occ_reg);
            if (!req_type_ok) begin
                m_data_next.status = STAT_BAD_TYPE;
            end else if (is_pub) begin
                m_data_next.status     = ring_full ? STAT_PUB_DROP : STAT_PUBLISHED;
                m_data_next.fill_level = 4'(occ_after);
            end else begin
                m_data_next.status = list_full ? STAT_LIST_FULL : STAT_SUBSCRIBED;
            end
            m_valid_next = 1'b1;
        end else if (cmd.deliver) begin
            m_data_next                  = '0;
            m_data_next.status           = STAT_DELIVERY;
            m_data_next.target_id        = sub_rd_reg;
            m_data_next.out_type         = meta_rd_reg.ev_type;
            m_data_next.out_priority     = meta_rd_reg.ev_priority;
            m_data_next.out_timestamp    = meta_rd_reg.ev_time;
            m_data_next.out_payload_low  = pay_rd_reg[63:0];
            m_data_next.out_payload_high = pay_rd_reg[127:64];
            m_data_next.fill_level       = 4'(occ_reg);
            m_valid_next                 = 1'b1;
        end else if (cmd.done) begin
            m_data_next               = '0;
            m_data_next.status        = STAT_DRAIN_DONE;
            m_data_next.fill_level    = 4'(occ_reg);
            m_data_next.drained_count = 4'(drained_reg);
            m_data_next.last          = 1'b1;
            m_valid_next              = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg  <= m_data_next;
        ev_cnt_reg  <= ev_cnt_next;
        sub_idx_reg <= sub_idx_next;
        rem_reg     <= rem_next;
        drained_reg <= drained_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg         <= '0;
            rp_reg         <= '0;
            occ_reg        <= '0;
            slot_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
            for (int t = 0; t < EVENT_TYPES; t++) begin
                tally_reg[t] <= '0;
            end
        end else begin
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            occ_reg        <= occ_next;
            slot_valid_reg <= slot_valid_next;
            m_valid_reg    <= m_valid_next;
            if (sub_we) begin
                tally_reg[tally_idx] <= tally_rd + 1'b1;
            end
        end
    end

    assign sts.out_free = out_free;
    assign sts.rem_zero = (rem_reg == '0);
    assign sts.sub_more = (sub_idx_reg < ev_cnt_reg);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

[rtl/core/event_queue_dispatcher_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// event_queue_dispatcher_core
// Publish / subscribe event ring with per-type subscriber lists.
//
//   channel | ports                       | carries
//   --------+-----------------------------+--------------------------------
//   s_      | s_valid s_ready s_data      | request: publish/subscribe/process
//   m_      | m_valid m_ready m_data      | result: status, delivery, counts
//
// Publish and subscribe: accept, then commit and load the result. Process
// walks the stored events and their subscribers through the registered
// reads of the ring memory and the subscriber table memory.
// One request is in work at a time; s_ready is high only while idle.
// A full result register holds the sequencer, requests wait at s_ready.
// Synchronous active-low reset empties the ring and all subscriber lists.
// ----------------------------------------------------------------------------
module event_queue_dispatcher_core #(
    parameter int QUEUE_DEPTH   = 8,
    parameter int SUBS_PER_TYPE = 4,
    parameter int EVENT_TYPES   = 11
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire eqd_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output eqd_pkg::out_item_t      m_data
);
    import eqd_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer
    eqd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_kind (s_data.kind),
        .sts     (sts),
        .cmd     (cmd)
    );

    // storage and result path
    eqd_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .SUBS_PER_TYPE (SUBS_PER_TYPE),
        .EVENT_TYPES   (EVENT_TYPES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

[rtl/core/eqd_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eqd_checker
// Port-level checks of the event queue dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module eqd_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire eqd_pkg::in_item_t  s_data,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire eqd_pkg::out_item_t m_data
);
    import eqd_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // no result is pending after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // no new request is taken while a drain is still delivering
    a_no_accept_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STAT_DELIVERY) |-> !s_ready)
        else $error("request accepted during drain");

    // a drain leaves the ring empty
    a_drain_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STAT_DELIVERY || m_data.status == STAT_DRAIN_DONE)
        |-> (m_data.fill_level == 4'd0))
        else $error("fill level not zero during drain");

endmodule

bind event_queue_dispatcher_core eqd_checker u_eqd_checker (.*);
`default_nettype wire

[tb/sv/eqd_scoreboard.sv]
// ----------------------------------------------------------------------------
// eqd_scoreboard
// Watches both channels of the event queue dispatcher. Every accepted request
// runs through a local model of the ring and the subscriber lists. Every
// accepted result is checked field by field against the oldest one still due.
// ----------------------------------------------------------------------------
module eqd_scoreboard #(
    parameter int QUEUE_DEPTH   = 8,
    parameter int SUBS_PER_TYPE = 4,
    parameter int EVENT_TYPES   = 11
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  eqd_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  eqd_pkg::out_item_t m_data,
    output int                 mismatch_total,
    output int                 results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import eqd_pkg::*;

    // local copy of the ring
    logic [3:0]  ring_type [QUEUE_DEPTH];
    logic [1:0]  ring_prio [QUEUE_DEPTH];
    logic [31:0] ring_time [QUEUE_DEPTH];
    logic [63:0] ring_lo   [QUEUE_DEPTH];
    logic [63:0] ring_hi   [QUEUE_DEPTH];
    int unsigned wr_slot;
    int unsigned rd_slot;
    int unsigned held;

    // local copy of the subscriber lists
    logic [7:0]  sub_ids [EVENT_TYPES][SUBS_PER_TYPE];
    int unsigned sub_count [EVENT_TYPES];

    out_item_t   due_results [$];
    int          result_no = 0;

    initial begin
        mismatch_total = 0;
        results_owed   = 0;
    end

    // one line per mismatch, and count it
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] result %0d: %s got %h want %h",
                 $realtime, result_no, what, got, want);
        mismatch_total++;
    endtask

    function automatic logic [63:0] lane_mask(input int unsigned n);
        if (n >= 8)
            return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic out_item_t status_word(input logic [2:0] st,
                                              input int unsigned fill,
                                              input int unsigned drained);
        out_item_t r;
        r = '0;
        r.status        = st;
        r.fill_level    = fill[3:0];
        r.drained_count = drained[3:0];
        r.last          = 1'b1;
        return r;
    endfunction

    // results that one request must cause
    task automatic compute_results(input in_item_t req);
        int unsigned n;
        int unsigned start;
        int unsigned et;
        int unsigned cnt;
        logic [2:0]  st;
        logic [63:0] ml;
        logic [63:0] mh;
        out_item_t   r;
        case (req.kind)
            KIND_PUBLISH: begin
                if (req.event_type >= EVENT_TYPES) begin
                    due_results.push_back(status_word(STAT_BAD_TYPE, held, 0));
                end else begin
                    st = STAT_PUBLISHED;
                    // full ring loses its oldest event
                    if (held >= QUEUE_DEPTH) begin
                        rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
                        held--;
                        st = STAT_PUB_DROP;
                    end
                    ring_type[wr_slot] = req.event_type;
                    ring_prio[wr_slot] = req.priority_req;
                    ring_time[wr_slot] = req.timestamp;
                    // partial payload keeps the untouched bytes of the slot
                    if (req.payload_present && req.payload_len != 0) begin
                        n  = (req.payload_len > PAYLOAD_BYTES) ? PAYLOAD_BYTES
                                                               : req.payload_len;
                        ml = lane_mask(n);
                        mh = (n > 8) ? lane_mask(n - 8) : 64'd0;
                        ring_lo[wr_slot] = (ring_lo[wr_slot] & ~ml) | (req.payload_low & ml);
                        ring_hi[wr_slot] = (ring_hi[wr_slot] & ~mh) | (req.payload_high & mh);
                    end else begin
                        ring_lo[wr_slot] = '0;
                        ring_hi[wr_slot] = '0;
                    end
                    wr_slot = (wr_slot + 1) % QUEUE_DEPTH;
                    held++;
                    due_results.push_back(status_word(st, held, 0));
                end
            end
            KIND_SUBSCRIBE: begin
                if (req.event_type >= EVENT_TYPES) begin
                    due_results.push_back(status_word(STAT_BAD_TYPE, held, 0));
                end else if (sub_count[req.event_type] >= SUBS_PER_TYPE) begin
                    due_results.push_back(status_word(STAT_LIST_FULL, held, 0));
                end else begin
                    sub_ids[req.event_type][sub_count[req.event_type]] = req.subscriber_id;
                    sub_count[req.event_type]++;
                    due_results.push_back(status_word(STAT_SUBSCRIBED, held, 0));
                end
            end
            KIND_PROCESS: begin
                // ring reads empty for every result of the drain
                start = held;
                held  = 0;
                for (int i = 0; i < start; i++) begin
                    et  = ring_type[rd_slot];
                    cnt = (et < EVENT_TYPES) ? sub_count[et] : 0;
                    for (int s = 0; s < cnt; s++) begin
                        r = '0;
                        r.status           = STAT_DELIVERY;
                        r.target_id        = sub_ids[et][s];
                        r.out_type         = ring_type[rd_slot];
                        r.out_priority     = ring_prio[rd_slot];
                        r.out_timestamp    = ring_time[rd_slot];
                        r.out_payload_low  = ring_lo[rd_slot];
                        r.out_payload_high = ring_hi[rd_slot];
                        due_results.push_back(r);
                    end
                    rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
                end
                due_results.push_back(status_word(STAT_DRAIN_DONE, 0, start));
            end
            default: ;
        endcase
    endtask

    task automatic compare_result(input out_item_t got, input out_item_t want);
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.target_id !== want.target_id)
            report_mismatch("target_id", got.target_id, want.target_id);
        if (got.out_type !== want.out_type)
            report_mismatch("out_type", got.out_type, want.out_type);
        if (got.out_priority !== want.out_priority)
            report_mismatch("out_priority", got.out_priority, want.out_priority);
        if (got.out_timestamp !== want.out_timestamp)
            report_mismatch("out_timestamp", got.out_timestamp, want.out_timestamp);
        if (got.out_payload_low !== want.out_payload_low)
            report_mismatch("out_payload_low", got.out_payload_low, want.out_payload_low);
        if (got.out_payload_high !== want.out_payload_high)
            report_mismatch("out_payload_high", got.out_payload_high, want.out_payload_high);
        if (got.fill_level !== want.fill_level)
            report_mismatch("fill_level", got.fill_level, want.fill_level);
        if (got.drained_count !== want.drained_count)
            report_mismatch("drained_count", got.drained_count, want.drained_count);
        if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
    endtask

    // sample both channels at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                ring_type[i] = '0;
                ring_prio[i] = '0;
                ring_time[i] = '0;
                ring_lo[i]   = '0;
                ring_hi[i]   = '0;
            end
            for (int t = 0; t < EVENT_TYPES; t++) begin
                sub_count[t] = 0;
                for (int s = 0; s < SUBS_PER_TYPE; s++)
                    sub_ids[t][s] = '0;
            end
            wr_slot = 0;
            rd_slot = 0;
            held    = 0;
            due_results.delete();
        end else begin
            if (s_valid && s_ready)
                compute_results(s_data);
            if (m_valid && m_ready) begin
                if (due_results.size() == 0)
                    report_mismatch("unexpected result, status", m_data.status, '0);
                else
                    compare_result(m_data, due_results.pop_front());
                result_no++;
            end
        end
        results_owed <= due_results.size();
    end

endmodule

[tb/sv/event_queue_dispatcher_core_tb.sv]
// ----------------------------------------------------------------------------
// event_queue_dispatcher_core_tb
// Drives publish, subscribe and process requests into the dispatcher: a
// directed opening over list limits, bad types, ring overflow and partial
// payloads, then random traffic under three idling mixes and one long result
// stall. The scoreboard beside the block checks every result.
// ----------------------------------------------------------------------------
module event_queue_dispatcher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import eqd_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    in_item_t  s_data  = '0;
    logic      m_ready = 1'b0;
    logic      s_ready;
    logic      m_valid;
    out_item_t m_data;

    int        mismatch_total;
    int        results_owed;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        hold_go   = 1'b0;
    bit        hold_done = 1'b0;

    event_queue_dispatcher_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    eqd_scoreboard scoreboard (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_total (mismatch_total),
        .results_owed   (results_owed)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random stalls, plus one long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_go && !hold_done) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // request with random filler in every field
    function automatic in_item_t noisy_req(input logic [1:0] kind, input logic [3:0] ty);
        in_item_t r;
        r.kind            = kind;
        r.event_type      = ty;
        r.priority_req    = $urandom;
        r.timestamp       = $urandom;
        r.payload_present = $urandom;
        r.payload_len     = $urandom;
        r.payload_low     = {$urandom, $urandom};
        r.payload_high    = {$urandom, $urandom};
        r.subscriber_id   = $urandom;
        return r;
    endfunction

    // mostly short payloads, some full range sizes
    function automatic in_item_t random_publish();
        in_item_t r;
        r = noisy_req(KIND_PUBLISH, $urandom_range(10));
        if ($urandom_range(9) < 7)
            r.payload_len = $urandom_range(20);
        r.payload_present = ($urandom_range(99) < 85);
        return r;
    endfunction

    function automatic in_item_t random_req();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return random_publish();
        if (pick < 65)
            return noisy_req(KIND_SUBSCRIBE, $urandom_range(10));
        if (pick < 80)
            return noisy_req(KIND_PROCESS, $urandom);
        if (pick < 92)
            return noisy_req($urandom_range(1), $urandom_range(15, 11));
        return noisy_req(KIND_UNUSED, $urandom);
    endfunction

    // hold the request on the channel until it is taken
    task automatic offer(input in_item_t req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic run_phase(input int count, input int s_idle, input int r_idle);
        int sent;
        int burst;
        in_item_t r;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        sent = 0;
        while (sent < count) begin
            // publish bursts push the ring into overflow
            if ($urandom_range(15) == 0) begin
                burst = $urandom_range(12, 4);
                repeat (burst) offer(random_publish());
                sent += burst;
            end else begin
                r = random_req();
                offer(r);
                if (r.kind != KIND_UNUSED)
                    sent++;
            end
        end
    endtask

    initial begin
        in_item_t r;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 17;
        recv_idle_pct = 83;

        // drain of an empty ring
        offer(noisy_req(KIND_PROCESS, 4'd0));

        // subscriber lists: duplicates, full list, bad types
        r = noisy_req(KIND_SUBSCRIBE, 4'd0);  r.subscriber_id = 8'h00; offer(r);
        r = noisy_req(KIND_SUBSCRIBE, 4'd0);  r.subscriber_id = 8'hFF; offer(r);
        r = noisy_req(KIND_SUBSCRIBE, 4'd0);  r.subscriber_id = 8'h00; offer(r);
        r = noisy_req(KIND_SUBSCRIBE, 4'd0);  r.subscriber_id = 8'h5A; offer(r);
        r = noisy_req(KIND_SUBSCRIBE, 4'd0);  r.subscriber_id = 8'h77; offer(r);
        r = noisy_req(KIND_SUBSCRIBE, 4'd10); r.subscriber_id = 8'hA5; offer(r);
        offer(noisy_req(KIND_SUBSCRIBE, 4'd11));
        offer(noisy_req(KIND_SUBSCRIBE, 4'd15));

        // publish with bad types
        offer(noisy_req(KIND_PUBLISH, 4'd11));
        offer(noisy_req(KIND_PUBLISH, 4'd15));

        // fill the ring with full payloads
        for (int i = 0; i < 8; i++) begin
            r = noisy_req(KIND_PUBLISH, (i == 3) ? 4'd5 : ((i % 2) ? 4'd10 : 4'd0));
            r.priority_req    = i % 4;
            r.timestamp       = (i == 0) ? 32'd0 : ((i == 1) ? '1 : r.timestamp);
            r.payload_present = 1'b1;
            r.payload_len     = (i == 7) ? 8'd255 : 8'd16;
            if (i != 1) begin
                r.payload_low  = '1;
                r.payload_high = '1;
            end
            offer(r);
        end

        // overflow: partial writes over old bytes, cleared payloads
        r = noisy_req(KIND_PUBLISH, 4'd0);  r.payload_present = 1'b1;
        r.payload_len = 8'd3;   r.payload_low = '0; r.payload_high = '0; offer(r);
        r = noisy_req(KIND_PUBLISH, 4'd10); r.payload_present = 1'b1;
        r.payload_len = 8'd9;   r.payload_low = '0; r.payload_high = '0; offer(r);
        r = noisy_req(KIND_PUBLISH, 4'd0);  r.payload_present = 1'b1;
        r.payload_len = 8'd0;   offer(r);
        r = noisy_req(KIND_PUBLISH, 4'd10); r.payload_present = 1'b0;
        r.payload_len = 8'd200; offer(r);
        r = noisy_req(KIND_PUBLISH, 4'd0);  r.payload_present = 1'b1;
        r.payload_len = 8'd15;  r.payload_low = '0; r.payload_high = '0; offer(r);

        // full drain with deliveries, then an ignored kind
        offer(noisy_req(KIND_PROCESS, 4'd15));
        offer(noisy_req(KIND_UNUSED, 4'd0));

        // random traffic
        run_phase(135, 17, 83);
        run_phase(135, 83, 17);
        hold_go = 1'b1;
        run_phase(135, 0, 0);
        s_valid <= 1'b0;

        // let the last results come out, the owed count is registered in the scoreboard
        @(posedge aclk);
        while (results_owed != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatch_total == 0 && results_owed == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/eqd_pkg.sv
rtl/core/eqd_ctrl.sv
rtl/core/eqd_datapath.sv
rtl/core/event_queue_dispatcher_core.sv
rtl/core/eqd_checker.sv
tb/sv/eqd_scoreboard.sv
tb/sv/event_queue_dispatcher_core_tb.sv
